/* rtl/core/pesu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesu_pkg
// Shared types, constants and helpers of the elastic stress update core.
// ----------------------------------------------------------------------------
package pesu_pkg;

   localparam int NUM_PARTICLES = 1024;
   localparam int PIDX_W        = 10;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
   localparam int CSR_IDX_W     = 8;

   localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
   // floor(x/3) for 32 bit x is (x * RECIP3) >> 33
   localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;

   localparam logic [CSR_IDX_W-1:0] REG_TIME_STEP     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHEAR_MODULUS = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BULK_MODULUS  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POISSON_RATIO = 8'd3;

   localparam logic [31:0] RST_TIME_STEP     = 32'd0;
   localparam logic [30:0] RST_SHEAR_MODULUS = 31'd26214400;
   localparam logic [30:0] RST_BULK_MODULUS  = 31'd43690667;
   localparam logic [30:0] RST_POISSON_RATIO = 31'd1073741824;

   typedef enum logic {
      FUNC_UPDATE = 1'b0,
      FUNC_INIT   = 1'b1
   } func_type;

   typedef struct packed {
      func_type          func;
      logic [PIDX_W-1:0] particle;
      logic              in_range;
      logic [8:0][31:0]  grad;
      logic [30:0]       vol;
   } item_type;

   typedef struct packed {
      logic [31:0] time_step;
      logic [30:0] shear_modulus;
      logic [30:0] bulk_modulus;
      logic [30:0] poisson_ratio;
   } cfg_type;

   typedef struct packed {
      logic [PIDX_W-1:0] particle;
      logic [5:0][31:0]  sig;
      logic [30:0]       volume;
   } result_type;

   function automatic logic [31:0] sat32(input logic signed [51:0] v);
      logic [31:0] r;
      if (v > 52'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -52'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* rtl/core/pesu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesu_front
// Takes requests, checks the particle range and hands them to the queue.
// ----------------------------------------------------------------------------
module pesu_front import pesu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_func,
   input  logic [PIDX_W-1:0] in_particle,
   input  logic [8:0][31:0]  in_grad,
   input  logic [30:0]       in_vol,
   output logic              push_valid,
   input  logic              push_ready,
   output item_type          push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign in_ready = !valid_ff || push_ready;

   always_comb begin
      item_in.func     = in_func ? FUNC_INIT : FUNC_UPDATE;
      item_in.particle = in_particle;
      item_in.in_range = (32'(in_particle) < 32'(NUM_PARTICLES));
      item_in.grad     = in_grad;
      item_in.vol      = in_vol;
      valid_in         = in_valid || (valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule

/* rtl/core/pesu_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesu_fifo
// Short request queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
module pesu_fifo import pesu_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_PTR_W:0]     count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/core/pesu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesu_back
// Per-particle stores and the update pipeline: read, gradient scaling,
// deformation and strain products, modulus products, write back.
// ----------------------------------------------------------------------------
module pesu_back import pesu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   output logic       q_ready,
   input  item_type   q_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   // per particle stores
   logic [8:0][31:0] def_mem [NUM_PARTICLES];
   logic [5:0][31:0] str_mem [NUM_PARTICLES];
   logic [30:0]      vol_mem [NUM_PARTICLES];

   logic             adv, hazard, issue;

   // lame constant, refreshed continuously from the moduli
   logic [63:0]         third_ff;
   logic signed [31:0]  lam_ff, lam_in;

   // stage 1
   logic             b1_v_ff;
   item_type         b1_ff;
   logic [8:0][31:0] def_q_ff;
   logic [5:0][31:0] str_q_ff;
   logic [30:0]      vol_q_ff;

   // stage 2
   logic                b2_v_ff;
   item_type            b2_ff;
   logic signed [64:0]  ldp_ff [9];
   logic signed [64:0]  ldp_in [9];
   logic [8:0][31:0]    b2_f_ff;
   logic [5:0][31:0]    b2_s_ff;
   logic [30:0]         b2_vol_ff;

   // stage 3
   logic                b3_v_ff;
   item_type            b3_ff;
   logic signed [31:0]  ld [9];
   logic signed [63:0]  fp_ff [27];
   logic signed [63:0]  fp_in [27];
   logic signed [63:0]  tp_ff, tp_in;
   logic signed [31:0]  ld0_ff;
   logic signed [31:0]  eoff_ff [3];
   logic signed [31:0]  eoff_in [3];
   logic [8:0][31:0]    b3_f_ff;
   logic [5:0][31:0]    b3_s_ff;
   logic [30:0]         b3_vol_ff;

   // stage 4
   logic                b4_v_ff;
   item_type            b4_ff;
   logic [8:0][31:0]    nf_ff, nf_in;
   logic signed [31:0]  t;
   logic signed [33:0]  ev;
   logic signed [32:0]  e [6];
   logic signed [65:0]  gp_ff [6];
   logic signed [65:0]  gp_in [6];
   logic signed [65:0]  lp_ff, lp_in, vp_ff, vp_in;
   logic [5:0][31:0]    b4_s_ff;
   logic [30:0]         b4_vol_ff;

   // write back
   logic [5:0][31:0]    s_new;
   logic signed [51:0]  v_sum;
   logic [30:0]         v_new;
   logic [8:0][31:0]    f_wr;
   logic [5:0][31:0]    s_wr;
   logic [30:0]         v_wr;
   result_type          res_in, res_ff;
   logic                out_v_ff;

   assign adv    = !out_v_ff || out_ready;
   assign hazard = (b1_v_ff && b1_ff.particle == q_item.particle)
                || (b2_v_ff && b2_ff.particle == q_item.particle)
                || (b3_v_ff && b3_ff.particle == q_item.particle)
                || (b4_v_ff && b4_ff.particle == q_item.particle);
   assign issue   = adv && q_valid && !hazard;
   assign q_ready = issue;

   assign lam_in = $signed({1'b0, cfg.bulk_modulus}) - $signed({1'b0, third_ff[63:33]});

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         ldp_in[i] = $signed(b1_ff.grad[i]) * $signed({1'b0, cfg.time_step});
      end
   end

   always_comb begin
      logic signed [32:0] s0, s1, s2;
      for (int i = 0; i < 9; i++) begin
         ld[i] = ldp_ff[i][63:32];
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 3; k++) begin
               fp_in[r*9 + c*3 + k] = ld[r*3 + k] * $signed(b2_f_ff[k*3 + c]);
            end
         end
      end
      tp_in      = ld[0] * $signed({1'b0, cfg.poisson_ratio});
      s0         = 33'(ld[1]) + 33'(ld[3]);
      s1         = 33'(ld[5]) + 33'(ld[7]);
      s2         = 33'(ld[2]) + 33'(ld[6]);
      eoff_in[0] = s0[32:1];
      eoff_in[1] = s1[32:1];
      eoff_in[2] = s2[32:1];
   end

   always_comb begin
      logic signed [49:0] acc;
      for (int rc = 0; rc < 9; rc++) begin
         acc = 50'($signed(b3_f_ff[rc]));
         for (int k = 0; k < 3; k++) begin
            acc = acc + 50'($signed(fp_ff[rc*3 + k][63:16]));
         end
         nf_in[rc] = sat32(52'(acc));
      end
      t    = tp_ff[63:32];
      ev   = 34'(ld0_ff) - 34'(t) - 34'(t);
      e[0] = 33'(ld0_ff);
      e[1] = -33'(t);
      e[2] = -33'(t);
      e[3] = 33'(eoff_ff[0]);
      e[4] = 33'(eoff_ff[1]);
      e[5] = 33'(eoff_ff[2]);
      for (int i = 0; i < 6; i++) begin
         gp_in[i] = $signed({1'b0, cfg.shear_modulus, 1'b0}) * e[i];
      end
      lp_in = lam_ff * ev;
      vp_in = ev * $signed({1'b0, b3_vol_ff});
   end

   always_comb begin
      logic signed [51:0] s;
      for (int i = 0; i < 6; i++) begin
         s = 52'($signed(b4_s_ff[i])) + 52'($signed(gp_ff[i][65:16]));
         if (i < 3) begin
            s = s + 52'($signed(lp_ff[65:16]));
         end
         s_new[i] = sat32(s);
      end
      v_sum = 52'($signed({1'b0, b4_vol_ff})) + 52'($signed(vp_ff[65:16]));
      if (v_sum < 0) begin
         v_new = '0;
      end else if (v_sum > 52'sd2147483647) begin
         v_new = 31'h7FFF_FFFF;
      end else begin
         v_new = v_sum[30:0];
      end

      if (b4_ff.func == FUNC_INIT) begin
         for (int i = 0; i < 9; i++) begin
            f_wr[i] = (i % 4 == 0) ? ONE_Q16 : 32'd0;
         end
         s_wr = '0;
         v_wr = b4_ff.vol;
      end else begin
         f_wr = nf_ff;
         s_wr = s_new;
         v_wr = v_new;
      end

      res_in.particle = b4_ff.particle;
      if (b4_ff.in_range) begin
         res_in.sig    = s_wr;
         res_in.volume = v_wr;
      end else begin
         res_in.sig    = '0;
         res_in.volume = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff  <= 1'b0;
         b2_v_ff  <= 1'b0;
         b3_v_ff  <= 1'b0;
         b4_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         b1_v_ff  <= issue;
         b2_v_ff  <= b1_v_ff;
         b3_v_ff  <= b2_v_ff;
         b4_v_ff  <= b3_v_ff;
         out_v_ff <= b4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      third_ff <= 64'({cfg.shear_modulus, 1'b0}) * 64'(RECIP3);
      lam_ff   <= lam_in;
      if (issue) begin
         b1_ff    <= q_item;
         def_q_ff <= def_mem[q_item.particle];
         str_q_ff <= str_mem[q_item.particle];
         vol_q_ff <= vol_mem[q_item.particle];
      end
      if (adv) begin
         b2_ff     <= b1_ff;
         ldp_ff    <= ldp_in;
         b2_f_ff   <= def_q_ff;
         b2_s_ff   <= str_q_ff;
         b2_vol_ff <= vol_q_ff;

         b3_ff     <= b2_ff;
         fp_ff     <= fp_in;
         tp_ff     <= tp_in;
         ld0_ff    <= ld[0];
         eoff_ff   <= eoff_in;
         b3_f_ff   <= b2_f_ff;
         b3_s_ff   <= b2_s_ff;
         b3_vol_ff <= b2_vol_ff;

         b4_ff     <= b3_ff;
         nf_ff     <= nf_in;
         gp_ff     <= gp_in;
         lp_ff     <= lp_in;
         vp_ff     <= vp_in;
         b4_s_ff   <= b3_s_ff;
         b4_vol_ff <= b3_vol_ff;

         res_ff    <= res_in;
      end
      if (adv && b4_v_ff && b4_ff.in_range) begin
         def_mem[b4_ff.particle] <= f_wr;
         str_mem[b4_ff.particle] <= s_wr;
         vol_mem[b4_ff.particle] <= v_wr;
      end
   end

   assign out_valid  = out_v_ff;
   assign out_result = res_ff;

endmodule

/* rtl/core/particle_elastic_stress_update_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_elastic_stress_update_core
// Hypoelastic stress, deformation and volume update of material points.
// ----------------------------------------------------------------------------
// One request updates (or initialises) one particle and gives one response
// with its new stress and volume. Requests for different particles are taken
// one per clock while the response side does not stall; a request for a
// particle that is still in the update pipeline waits until that particle has
// been written back. Each request passes the front register, the queue and
// the back pipeline stages, and its response is registered at the output.
// Registers may only be written while the core is idle. A particle must be
// initialised before its first update.
module particle_elastic_stress_update_core import pesu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // particle[9:0], grad_xx..grad_zz (row-major, 32 bit each) from bit 10,
   // initial_volume[328:298], zero pad
   input  logic [335:0]         req_tdata,
   // func
   input  logic [0:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // out_particle[9:0], sig_xx[41:10], sig_yy[73:42], sig_zz[105:74],
   // sig_xy[137:106], sig_yz[169:138], sig_xz[201:170],
   // new_volume[232:202], zero pad
   output logic [239:0]         rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   cfg_type          cfg_ff;
   logic [8:0][31:0] grad;
   logic             push_valid, push_ready, pop_valid, pop_ready;
   item_type         push_item, pop_item;
   result_type       res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_step     <= RST_TIME_STEP;
         cfg_ff.shear_modulus <= RST_SHEAR_MODULUS;
         cfg_ff.bulk_modulus  <= RST_BULK_MODULUS;
         cfg_ff.poisson_ratio <= RST_POISSON_RATIO;
      end else if (csr_valid) begin
         case (csr_index)
            REG_TIME_STEP:     cfg_ff.time_step     <= csr_data;
            REG_SHEAR_MODULUS: cfg_ff.shear_modulus <= csr_data[30:0];
            REG_BULK_MODULUS:  cfg_ff.bulk_modulus  <= csr_data[30:0];
            REG_POISSON_RATIO: cfg_ff.poisson_ratio <= csr_data[30:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         grad[i] = req_tdata[10 + 32*i +: 32];
      end
   end

   pesu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_func     (req_tuser[0]),
      .in_particle (req_tdata[9:0]),
      .in_grad     (grad),
      .in_vol      (req_tdata[328:298]),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   pesu_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   pesu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (pop_valid),
      .q_ready    (pop_ready),
      .q_item     (pop_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (res)
   );

   assign rsp_tdata = {7'd0, res.volume, res.sig[5], res.sig[4], res.sig[3],
                       res.sig[2], res.sig[1], res.sig[0], res.particle};

endmodule
